// ===== hdl/rpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_pkg
// Types and constants shared by the rotator position controller modules.
// ----------------------------------------------------------------------------
package rpc_pkg;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_SEEK   = 2'd1,
		CMD_STOP   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_STOP    = 3'd0,
		MODE_CW      = 3'd1,
		MODE_CCW     = 3'd2,
		MODE_MAN_CW  = 3'd3,
		MODE_MAN_CCW = 3'd4
	} mode_t;

	// configuration register indexes
	typedef enum logic {
		REG_CCW_LIMIT = 1'b0,
		REG_CW_LIMIT  = 1'b1
	} reg_idx_t;

	// switch lines, active low: bit0 CCW request, bit1 CW request
	localparam logic [1:0] SW_RELEASED = 2'b11;

	// relay pair: bit0 CW relay, bit1 CCW relay
	localparam logic [1:0] RELAY_OFF = 2'b00;
	localparam logic [1:0] RELAY_CW  = 2'b01;
	localparam logic [1:0] RELAY_CCW = 2'b10;

	localparam logic [1:0] FAULT_CCW = 2'b01;
	localparam logic [1:0] FAULT_CW  = 2'b10;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] relays;
		logic [1:0] faults;
	} rpc_status_t;

endpackage : rpc_pkg
`default_nettype wire

// ===== hdl/rpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_ctrl
// Controller state and its update: median-of-three filter,
// end limits, target check, switch handling and commands.
// ----------------------------------------------------------------------------
module rpc_ctrl
	import rpc_pkg::*;
#(
	parameter int SENSOR_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire cmd_t                   cmd,
	input  wire logic [SENSOR_BITS-1:0] sample,
	input  wire logic [1:0]             sw,
	input  wire logic [SENSOR_BITS-1:0] target,
	input  wire logic [SENSOR_BITS-1:0] ccw_limit,
	input  wire logic [SENSOR_BITS-1:0] cw_limit,
	output rpc_status_t                 status_next,
	output logic [SENSOR_BITS-1:0]      position_next
);

	logic [SENSOR_BITS-1:0] win_q [3];
	logic [1:0]             slot_q;
	logic [SENSOR_BITS-1:0] filt_q;
	logic [SENSOR_BITS-1:0] goal_q;
	mode_t                  mode_q;
	logic [1:0]             relays_q;
	logic [1:0]             faults_q;
	logic [1:0]             last_sw_q;
	logic                   sw_seen_q;

	logic [SENSOR_BITS-1:0] win_d [3];
	logic [1:0]             slot_d;
	logic [SENSOR_BITS-1:0] filt_d;
	logic [SENSOR_BITS-1:0] goal_d;
	mode_t                  mode_d;
	logic [1:0]             relays_d;
	logic [1:0]             faults_d;
	logic [1:0]             last_sw_d;
	logic                   sw_seen_d;
	logic [SENSOR_BITS-1:0] med;
	logic                   ab, ac, bc;

	// median of the window after this sample is written
	always_comb begin
		ab = win_d[0] <= win_d[1];
		ac = win_d[0] <= win_d[2];
		bc = win_d[1] <= win_d[2];
		if (ab && ac) begin
			med = bc ? win_d[1] : win_d[2];
		end else if (!ab && bc) begin
			med = ac ? win_d[0] : win_d[2];
		end else begin
			med = ab ? win_d[0] : win_d[1];
		end
	end

	always_comb begin
		win_d     = win_q;
		slot_d    = slot_q;
		filt_d    = filt_q;
		goal_d    = goal_q;
		mode_d    = mode_q;
		relays_d  = relays_q;
		faults_d  = faults_q;
		last_sw_d = last_sw_q;
		sw_seen_d = sw_seen_q;

		if (cmd == CMD_SAMPLE) begin
			unique case (slot_q)
				2'd0: win_d[0] = sample;
				2'd1: win_d[1] = sample;
				2'd2: win_d[2] = sample;
				default: ;
			endcase
		end

		unique case (cmd)
			CMD_SAMPLE: begin
				slot_d = (slot_q >= 2'd2) ? 2'd0 : slot_q + 2'd1;
				filt_d = med;
				if (mode_q == MODE_CW || mode_q == MODE_CCW) begin
					if (med <= ccw_limit) begin
						faults_d = faults_q | FAULT_CCW;
						relays_d = relays_q & ~RELAY_CCW;
					end else if (med >= cw_limit) begin
						faults_d = faults_q | FAULT_CW;
						relays_d = relays_q & ~RELAY_CW;
					end
				end
				if ((mode_q == MODE_CW && med > goal_q) ||
				    (mode_q == MODE_CCW && med <= goal_q)) begin
					mode_d   = MODE_STOP;
					relays_d = RELAY_OFF;
				end
				if (!sw_seen_q || sw != last_sw_q) begin
					if (sw_seen_q && last_sw_q == SW_RELEASED) begin
						if (!sw[0]) begin
							mode_d   = MODE_MAN_CCW;
							relays_d = RELAY_CCW;
						end else if (!sw[1]) begin
							mode_d   = MODE_MAN_CW;
							relays_d = RELAY_CW;
						end
					end else begin
						mode_d   = MODE_STOP;
						relays_d = RELAY_OFF;
					end
					last_sw_d = sw;
					sw_seen_d = 1'b1;
				end
			end
			CMD_SEEK: begin
				goal_d = target;
				if (target > filt_q) begin
					mode_d   = MODE_CW;
					relays_d = RELAY_CW;
				end else if (target < filt_q) begin
					mode_d   = MODE_CCW;
					relays_d = RELAY_CCW;
				end else begin
					mode_d   = MODE_STOP;
					relays_d = RELAY_OFF;
				end
			end
			CMD_STOP: begin
				mode_d   = MODE_STOP;
				relays_d = RELAY_OFF;
				faults_d = 2'b00;
			end
			CMD_CLEAR: begin
				faults_d = 2'b00;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '{default: '0};
			slot_q    <= 2'd0;
			filt_q    <= '0;
			goal_q    <= '0;
			mode_q    <= MODE_STOP;
			relays_q  <= RELAY_OFF;
			faults_q  <= 2'b00;
			last_sw_q <= 2'b00;
			sw_seen_q <= 1'b0;
		end else if (step) begin
			win_q     <= win_d;
			slot_q    <= slot_d;
			filt_q    <= filt_d;
			goal_q    <= goal_d;
			mode_q    <= mode_d;
			relays_q  <= relays_d;
			faults_q  <= faults_d;
			last_sw_q <= last_sw_d;
			sw_seen_q <= sw_seen_d;
		end
	end

	assign status_next.mode   = mode_d;
	assign status_next.relays = relays_d;
	assign status_next.faults = faults_d;
	assign position_next      = filt_d;

endmodule : rpc_ctrl
`default_nettype wire

// ===== hdl/rotator_position_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotator_position_controller
// Antenna rotator control from a filtered direction sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one item per transfer; s_tuser carries the command
//   (sample, seek, stop and clear, clear errors), s_tdata the sample,
//   switch lines and target. Master stream m_*: one status item per input
//   item, showing mode, relay drives, filtered position and error bits.
//   Config channel cfg_*: limit registers; the user writes them only while
//   idle, the block itself does not enforce this; cfg_ready is always high.
//   An input transfer passes the input register, then the state update
//   into the output buffer, before m_tvalid rises. Throughput: one item
//   per clock while m_tready is high.
//   Stalls: a two-entry output buffer holds results; s_tready drops once
//   the input register and both buffer entries are occupied.
//   Reset: arst_n clears the filter window, mode (stopped), relays,
//   errors, switch history and limits (CCW 0, CW 1023).
// ----------------------------------------------------------------------------
module rotator_position_controller
	import rpc_pkg::*;
#(
	parameter int SENSOR_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// sensor_sample, switch_lines, target_position
	input  wire logic [((2*SENSOR_BITS+2+7)/8)*8-1:0] s_tdata,
	// command
	input  wire logic [1:0]             s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// motion_mode, cw_drive, ccw_drive, filtered_position, error_bits
	output logic [((SENSOR_BITS+7+7)/8)*8-1:0] m_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_index,
	input  wire logic [SENSOR_BITS-1:0] cfg_data
);

	localparam int OUT_BITS = SENSOR_BITS + 7;
	localparam int OUT_W    = ((SENSOR_BITS + 7 + 7) / 8) * 8;

	logic [SENSOR_BITS-1:0] ccw_limit_q;
	logic [SENSOR_BITS-1:0] cw_limit_q;

	logic                   item_valid_s1;
	cmd_t                   cmd_s1;
	logic [SENSOR_BITS-1:0] sample_s1;
	logic [1:0]             sw_s1;
	logic [SENSOR_BITS-1:0] target_s1;

	logic                   out_valid_q;
	logic [OUT_BITS-1:0]    out_data_q;
	logic                   skid_valid_q;
	logic [OUT_BITS-1:0]    skid_data_q;

	rpc_status_t            status_next;
	logic [SENSOR_BITS-1:0] position_next;
	logic [OUT_BITS-1:0]    result;
	logic                   accept;
	logic                   advance;
	logic                   pop;
	logic [1:0]             occupancy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccw_limit_q <= '0;
			cw_limit_q  <= SENSOR_BITS'(1023);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CCW_LIMIT: ccw_limit_q <= cfg_data;
				REG_CW_LIMIT:  cw_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign occupancy = 2'(item_valid_s1) + 2'(out_valid_q) + 2'(skid_valid_q);
	assign s_tready  = occupancy <= 2'd2;
	assign accept    = s_tvalid && s_tready;
	assign advance   = item_valid_s1 && !(out_valid_q && skid_valid_q);
	assign pop       = out_valid_q && m_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd_t'(s_tuser);
			sample_s1 <= s_tdata[SENSOR_BITS-1:0];
			sw_s1     <= s_tdata[SENSOR_BITS+1:SENSOR_BITS];
			target_s1 <= s_tdata[2*SENSOR_BITS+1:SENSOR_BITS+2];
		end
	end

	rpc_ctrl #(
		.SENSOR_BITS(SENSOR_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.cmd          (cmd_s1),
		.sample       (sample_s1),
		.sw           (sw_s1),
		.target       (target_s1),
		.ccw_limit    (ccw_limit_q),
		.cw_limit     (cw_limit_q),
		.status_next  (status_next),
		.position_next(position_next)
	);

	assign result = {status_next.faults, position_next, status_next.relays[1],
	                 status_next.relays[0], status_next.mode};

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= advance;
			end else begin
				out_valid_q <= advance;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= advance;
		end else if (advance) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q  <= skid_data_q;
				skid_data_q <= result;
			end else begin
				out_data_q <= result;
			end
		end else if (!out_valid_q) begin
			out_data_q <= result;
		end else if (advance) begin
			skid_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);

endmodule : rotator_position_controller
`default_nettype wire
